// ===== rtl/agcm_pkg.sv =====
package agcm_pkg;

  localparam logic [3:0] ROUND_COUNT = 4'd10;

  typedef logic [127:0] block_t;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_FINISH = 1'b1
  } kind_t;

  localparam logic [2:0] REG_KEY_HIGH = 3'd0;
  localparam logic [2:0] REG_KEY_LOW  = 3'd1;
  localparam logic [2:0] REG_IV_HIGH  = 3'd2;
  localparam logic [2:0] REG_IV_LOW   = 3'd3;

  localparam logic [127:0] GHASH_POLY = {8'he1, 120'd0};
  localparam logic [7:0]   RCON_INIT  = 8'h01;

  // Control group from the sequencer to the AES core.
  typedef struct packed {
    logic   start;
    block_t din;
  } aes_req_t;

  // Control group from the sequencer to the GHASH multiplier.
  typedef struct packed {
    logic   start;
    block_t x;
    block_t h;
  } gh_req_t;

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[a];
  endfunction

endpackage

// ===== rtl/agcm_in_if.sv =====
interface agcm_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] block_high;
  logic [63:0] block_low;

  modport source (output valid, kind, block_high, block_low, input ready);
  modport sink   (input valid, kind, block_high, block_low, output ready);
endinterface

// ===== rtl/agcm_out_if.sv =====
interface agcm_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_high;
  logic [63:0] out_low;
  logic        is_tag;

  modport source (output valid, out_high, out_low, is_tag, input ready);
  modport sink   (input valid, out_high, out_low, is_tag, output ready);
endinterface

// ===== rtl/agcm_aes.sv =====
// AES-128 encryption, one byte per cycle. The state rotates through a 16-byte
// shift register, the round key sits in a 16-byte register; MixColumns and
// the key schedule word update are done at round boundaries on whole columns.
module agcm_aes (
  input  logic                 clk,
  input  logic                 rst_n,
  input  agcm_pkg::aes_req_t   req,
  input  agcm_pkg::block_t     key,
  output logic                 done,
  output agcm_pkg::block_t     dout
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SUB,
    S_MIX,
    S_DONE
  } state_t;

  state_t           state_r;
  logic [3:0]       byte_r;
  logic [3:0]       round_r;
  logic [7:0]       rcon_r;
  logic [7:0]       st_r  [16];
  logic [7:0]       rk_r  [16];

  logic [7:0]       sr    [16];
  logic [7:0]       mc    [16];
  logic [7:0]       nk    [16];
  logic [7:0]       w0, w1, w2, w3;
  logic [7:0]       a0, a1, a2, a3, al;
  logic [7:0]       sub_byte;

  // One S-box lookup per cycle: byte 0 leaves, substituted byte enters at 15.
  assign sub_byte = agcm_pkg::sbox(st_r[0]);

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sr[i] = '0;
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        sr[i + 4 * c] = st_r[i + 4 * ((c + i) % 4)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = sr[4 * c];
      a1 = sr[4 * c + 1];
      a2 = sr[4 * c + 2];
      a3 = sr[4 * c + 3];
      al = a0 ^ a1 ^ a2 ^ a3;
      mc[4 * c]     = a0 ^ al ^ agcm_pkg::xtime(a0 ^ a1);
      mc[4 * c + 1] = a1 ^ al ^ agcm_pkg::xtime(a1 ^ a2);
      mc[4 * c + 2] = a2 ^ al ^ agcm_pkg::xtime(a2 ^ a3);
      mc[4 * c + 3] = a3 ^ al ^ agcm_pkg::xtime(a3 ^ a0);
    end
    w0 = agcm_pkg::sbox(rk_r[13]) ^ rcon_r;
    w1 = agcm_pkg::sbox(rk_r[14]);
    w2 = agcm_pkg::sbox(rk_r[15]);
    w3 = agcm_pkg::sbox(rk_r[12]);
    nk[0] = rk_r[0] ^ w0;
    nk[1] = rk_r[1] ^ w1;
    nk[2] = rk_r[2] ^ w2;
    nk[3] = rk_r[3] ^ w3;
    for (int i = 4; i < 16; i++) begin
      nk[i] = rk_r[i] ^ nk[i - 4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      byte_r  <= '0;
      round_r <= '0;
      rcon_r  <= agcm_pkg::RCON_INIT;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (req.start) begin
            for (int i = 0; i < 16; i++) begin
              st_r[i] <= req.din[127 - 8 * i -: 8] ^ key[127 - 8 * i -: 8];
              rk_r[i] <= key[127 - 8 * i -: 8];
            end
            byte_r  <= '0;
            round_r <= 4'd1;
            rcon_r  <= agcm_pkg::RCON_INIT;
            state_r <= S_SUB;
          end
        end
        S_SUB: begin
          for (int i = 0; i < 15; i++) begin
            st_r[i] <= st_r[i + 1];
          end
          st_r[15] <= sub_byte;
          byte_r   <= byte_r + 4'd1;
          if (byte_r == 4'd15) begin
            state_r <= S_MIX;
          end
        end
        S_MIX: begin
          for (int i = 0; i < 16; i++) begin
            st_r[i] <= ((round_r == agcm_pkg::ROUND_COUNT) ? sr[i] : mc[i]) ^ nk[i];
            rk_r[i] <= nk[i];
          end
          rcon_r <= agcm_pkg::xtime(rcon_r);
          if (round_r == agcm_pkg::ROUND_COUNT) begin
            state_r <= S_DONE;
          end else begin
            round_r <= round_r + 4'd1;
            state_r <= S_SUB;
          end
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done = (state_r == S_DONE);

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      dout[127 - 8 * i -: 8] = st_r[i];
    end
  end

endmodule

// ===== rtl/agcm_ghash.sv =====
// GF(2^128) multiply, eight bits of H per cycle.
module agcm_ghash (
  input  logic               clk,
  input  logic               rst_n,
  input  agcm_pkg::gh_req_t  req,
  output logic               done,
  output agcm_pkg::block_t   z
);

  logic             busy_r;
  logic [3:0]       cnt_r;
  logic             done_r;
  logic [127:0]     v_r, z_r, h_r;
  logic [127:0]     v_n, z_n;

  always_comb begin
    v_n = v_r;
    z_n = z_r;
    for (int i = 0; i < 8; i++) begin
      if (h_r[127 - i]) begin
        z_n = z_n ^ v_n;
      end
      v_n = {1'b0, v_n[127:1]} ^ (v_n[0] ? agcm_pkg::GHASH_POLY : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        v_r    <= req.x;
        h_r    <= req.h;
        z_r    <= '0;
      end else if (busy_r) begin
        v_r   <= v_n;
        z_r   <= z_n;
        h_r   <= {h_r[119:0], 8'd0};
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign z    = z_r;

endmodule

// ===== rtl/aes128_gcm_encrypt.sv =====
// AES-128 GCM encryptor with no additional authenticated data.
// Configuration: APB-style port, 64-bit data, registers at byte addresses
// 0 (key high), 8 (key low), 16 (IV high), 24 (IV low, bits 31:0). A write
// takes effect at the access cycle; pready is always high.
// Input channel: valid/ready words carrying kind and a 128-bit block.
// A data word returns its ciphertext; a finish word returns the tag and
// closes the message. Output channel: one result word per input word.
// The first word of a message first computes H = E(0) and E(J0), two AES
// runs. After that a data word takes one AES run (ten rounds, each a
// byte-serial S-box pass over the state and a mix step), then a GHASH
// multiply; a finish word takes only a GHASH multiply.
// The byte-serial AES core sets the processing time.
// One word is processed at a time. The result sits in an output register
// until taken; the next word is accepted while it waits, and processing
// stalls only when a second result would need the register.
// Reset clears the configuration registers, the open-message flag and both channels.
module aes128_gcm_encrypt #(
  parameter int COUNT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  agcm_in_if.sink            in_ch,
  agcm_out_if.source         out_ch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [63:0]        cfg_pwdata,
  output logic [63:0]        cfg_prdata,
  output logic               cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_H_RUN,
    S_M_RUN,
    S_CHK,
    S_KS_RUN,
    S_GH_RUN,
    S_EMIT
  } state_t;

  state_t                 state_r;
  logic [63:0]            key_high_r, key_low_r, iv_high_r;
  logic [31:0]            iv_low_r;
  logic [127:0]           h_r, mask_r, acc_r, blk_r;
  logic [31:0]            ctr_r;
  logic [COUNT_BITS-1:0]  cnt_r;
  logic                   open_r;
  logic                   kind_r;
  logic                   hold_r;
  logic [127:0]           res_r;
  logic                   res_tag_r;
  logic                   ovalid_r;
  logic [127:0]           ohold_r;
  logic                   otag_r;

  agcm_pkg::aes_req_t     aes_req;
  agcm_pkg::gh_req_t      gh_req;
  logic                   aes_done, gh_done;
  agcm_pkg::block_t       aes_out, gh_out;
  logic [127:0]           key;
  logic                   cfg_wr;
  logic [2:0]             reg_idx;
  logic                   start_r;
  logic [127:0]           aes_din_r;
  logic                   gstart_r;
  logic [127:0]           gx_r;
  logic [127:0]           len_blk;
  logic [127:0]           ct;
  logic                   emit_go;

  assign key       = {key_high_r, key_low_r};
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx   = cfg_paddr[4:3] == 2'd0 ? agcm_pkg::REG_KEY_HIGH :
                     cfg_paddr[4:3] == 2'd1 ? agcm_pkg::REG_KEY_LOW :
                     cfg_paddr[4:3] == 2'd2 ? agcm_pkg::REG_IV_HIGH :
                                              agcm_pkg::REG_IV_LOW;
  assign cfg_pready = 1'b1;

  always_comb begin
    unique case (reg_idx)
      agcm_pkg::REG_KEY_HIGH: cfg_prdata = key_high_r;
      agcm_pkg::REG_KEY_LOW:  cfg_prdata = key_low_r;
      agcm_pkg::REG_IV_HIGH:  cfg_prdata = iv_high_r;
      default:                cfg_prdata = {32'd0, iv_low_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      iv_high_r  <= '0;
      iv_low_r   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        agcm_pkg::REG_KEY_HIGH: key_high_r <= cfg_pwdata;
        agcm_pkg::REG_KEY_LOW:  key_low_r  <= cfg_pwdata;
        agcm_pkg::REG_IV_HIGH:  iv_high_r  <= cfg_pwdata;
        default:                iv_low_r   <= cfg_pwdata[31:0];
      endcase
    end
  end

  assign aes_req.start = start_r;
  assign aes_req.din   = aes_din_r;
  assign gh_req.start  = gstart_r;
  assign gh_req.x      = gx_r;
  assign gh_req.h      = h_r;

  agcm_aes u_aes (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (aes_req),
    .key  (key),
    .done (aes_done),
    .dout (aes_out)
  );

  agcm_ghash u_ghash (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (gh_req),
    .done (gh_done),
    .z    (gh_out)
  );

  assign len_blk = {64'd0, {(57 - COUNT_BITS){1'b0}}, cnt_r, 7'd0};
  assign ct      = blk_r ^ aes_out;
  assign emit_go = (state_r == S_EMIT) && (!ovalid_r || out_ch.ready);

  assign in_ch.ready = !hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      open_r    <= 1'b0;
      ctr_r     <= 32'd1;
      cnt_r     <= '0;
      hold_r    <= 1'b0;
      start_r   <= 1'b0;
      gstart_r  <= 1'b0;
      ovalid_r  <= 1'b0;
      h_r       <= '0;
      mask_r    <= '0;
      acc_r     <= '0;
    end else begin
      start_r  <= 1'b0;
      gstart_r <= 1'b0;
      if (emit_go) begin
        ovalid_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
      if (in_ch.valid && !hold_r) begin
        hold_r <= 1'b1;
        kind_r <= in_ch.kind;
        blk_r  <= {in_ch.block_high, in_ch.block_low};
      end
      unique case (state_r)
        S_IDLE: begin
          if (hold_r) begin
            if (!open_r) begin
              aes_din_r <= '0;
              start_r   <= 1'b1;
              state_r   <= S_H_RUN;
            end else begin
              state_r <= S_CHK;
            end
          end
        end
        S_H_RUN: begin
          if (aes_done) begin
            h_r       <= aes_out;
            aes_din_r <= {iv_high_r, iv_low_r, 32'd1};
            start_r   <= 1'b1;
            state_r   <= S_M_RUN;
          end
        end
        S_M_RUN: begin
          if (aes_done) begin
            mask_r  <= aes_out;
            acc_r   <= '0;
            ctr_r   <= 32'd1;
            cnt_r   <= '0;
            open_r  <= 1'b1;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (kind_r == agcm_pkg::KIND_FINISH) begin
            gx_r     <= acc_r ^ len_blk;
            gstart_r <= 1'b1;
            state_r  <= S_GH_RUN;
          end else begin
            ctr_r     <= ctr_r + 32'd1;
            aes_din_r <= {iv_high_r, iv_low_r, ctr_r + 32'd1};
            start_r   <= 1'b1;
            state_r   <= S_KS_RUN;
          end
        end
        S_KS_RUN: begin
          if (aes_done) begin
            res_r     <= ct;
            res_tag_r <= 1'b0;
            gx_r      <= acc_r ^ ct;
            gstart_r  <= 1'b1;
            cnt_r     <= cnt_r + 1'b1;
            state_r   <= S_GH_RUN;
          end
        end
        S_GH_RUN: begin
          if (gh_done) begin
            acc_r <= gh_out;
            if (kind_r == agcm_pkg::KIND_FINISH) begin
              res_r     <= gh_out ^ mask_r;
              res_tag_r <= 1'b1;
              open_r    <= 1'b0;
              ctr_r     <= 32'd1;
              cnt_r     <= '0;
            end
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            ohold_r  <= res_r;
            otag_r   <= res_tag_r;
            hold_r   <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid    = ovalid_r;
  assign out_ch.out_high = ohold_r[127:64];
  assign out_ch.out_low  = ohold_r[63:0];
  assign out_ch.is_tag   = otag_r;

  a_one_engine: assert property (@(posedge clk) disable iff (!rst_n)
    !(u_aes.done && gh_done))
    else $error("AES and GHASH finished together");
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && (!ovalid_r || out_ch.ready)) |=> ovalid_r && !hold_r)
    else $error("result not moved to output");
  a_tag_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GH_RUN && gh_done && kind_r) |=> !open_r && cnt_r == '0)
    else $error("finish did not close message");

endmodule

// ===== sim/gcm_checker.sv =====
`timescale 1ns / 100ps

module gcm_checker (
  input  logic        clk,
  input  logic        rst_n,
  agcm_in_if          in_mon,
  agcm_out_if         out_mon,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output int          fail_count,
  output int          words_pending
);

  typedef struct {
    logic [127:0] text;
    logic         is_tag;
  } gcm_result_t;

  localparam logic [2047:0] SBOX_ROM = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

  logic [63:0]  key_hi, key_lo, iv_hi;
  logic [31:0]  iv_lo;
  logic [127:0] hash_key, tag_mask, ghash_acc;
  logic [31:0]  ctr_word, block_total;
  logic         msg_open;
  gcm_result_t  expected_results[$];

  function automatic logic [7:0] sub_byte(input logic [7:0] a);
    return SBOX_ROM[2047 - 8 * a -: 8];
  endfunction

  function automatic logic [7:0] gf_double(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] aes_encrypt(input logic [127:0] din);
    logic [7:0] st[16], rk[16], tmp[16], w[4];
    logic [7:0] rcon, a0, a1, a2, a3, sum;
    logic [127:0] dout;
    rcon = 8'h01;
    for (int i = 0; i < 16; i++) begin
      st[i] = din[127 - 8 * i -: 8];
      rk[i] = (i < 8) ? key_hi[63 - 8 * i -: 8] : key_lo[63 - 8 * (i - 8) -: 8];
      st[i] ^= rk[i];
    end
    for (int r = 1; r <= 10; r++) begin
      for (int i = 0; i < 16; i++) tmp[i] = sub_byte(st[i]);
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) st[i + 4 * c] = tmp[i + 4 * ((c + i) % 4)];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4 * c]; a1 = st[4 * c + 1]; a2 = st[4 * c + 2]; a3 = st[4 * c + 3];
          sum = a0 ^ a1 ^ a2 ^ a3;
          st[4 * c]     = a0 ^ sum ^ gf_double(a0 ^ a1);
          st[4 * c + 1] = a1 ^ sum ^ gf_double(a1 ^ a2);
          st[4 * c + 2] = a2 ^ sum ^ gf_double(a2 ^ a3);
          st[4 * c + 3] = a3 ^ sum ^ gf_double(a3 ^ a0);
        end
      end
      w[0] = sub_byte(rk[13]) ^ rcon;
      w[1] = sub_byte(rk[14]);
      w[2] = sub_byte(rk[15]);
      w[3] = sub_byte(rk[12]);
      for (int i = 0; i < 4; i++) rk[i] ^= w[i];
      for (int i = 4; i < 16; i++) rk[i] ^= rk[i - 4];
      rcon = gf_double(rcon);
      for (int i = 0; i < 16; i++) st[i] ^= rk[i];
    end
    for (int i = 0; i < 16; i++) dout[127 - 8 * i -: 8] = st[i];
    return dout;
  endfunction

  // GCM bit order: bit 127 of the vector is the coefficient of x^0.
  function automatic logic [127:0] ghash_mul(input logic [127:0] v_in, input logic [127:0] h);
    logic [127:0] v, z;
    logic lsb;
    v = v_in;
    z = '0;
    for (int i = 0; i < 128; i++) begin
      if (h[127 - i]) z ^= v;
      lsb = v[0];
      v = v >> 1;
      if (lsb) v[127:120] ^= 8'he1;
    end
    return z;
  endfunction

  task automatic predict_word(input logic kind, input logic [127:0] blk);
    gcm_result_t res;
    if (!msg_open) begin
      hash_key  = aes_encrypt('0);
      tag_mask  = aes_encrypt({iv_hi, iv_lo, 32'd1});
      ghash_acc = '0;
      ctr_word  = 32'd1;
      block_total = '0;
      msg_open  = 1'b1;
    end
    if (kind == agcm_pkg::KIND_DATA) begin
      ctr_word = ctr_word + 32'd1;
      res.text = blk ^ aes_encrypt({iv_hi, iv_lo, ctr_word});
      res.is_tag = 1'b0;
      ghash_acc = ghash_mul(ghash_acc ^ res.text, hash_key);
      block_total = block_total + 32'd1;
    end else begin
      ghash_acc = ghash_mul(ghash_acc ^ {64'd0, 25'd0, block_total, 7'd0}, hash_key);
      res.text = ghash_acc ^ tag_mask;
      res.is_tag = 1'b1;
      ctr_word = 32'd1;
      block_total = '0;
      msg_open = 1'b0;
    end
    expected_results.push_back(res);
  endtask

  always @(posedge clk) begin
    gcm_result_t want;
    if (!rst_n) begin
      key_hi <= '0; key_lo <= '0; iv_hi <= '0; iv_lo <= '0;
      hash_key = '0; tag_mask = '0; ghash_acc = '0;
      ctr_word = 32'd1; block_total = '0; msg_open = 1'b0;
      expected_results.delete();
      fail_count <= 0;
      words_pending <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word %h_%h tag %b",
                 out_mon.out_high, out_mon.out_low, out_mon.is_tag);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_mon.out_high !== want.text[127:64] || out_mon.out_low !== want.text[63:0]
              || out_mon.is_tag !== want.is_tag) begin
            if (out_mon.out_high !== want.text[127:64])
              $error("out_high expected %h actual %h", want.text[127:64], out_mon.out_high);
            if (out_mon.out_low !== want.text[63:0])
              $error("out_low expected %h actual %h", want.text[63:0], out_mon.out_low);
            if (out_mon.is_tag !== want.is_tag)
              $error("is_tag expected %b actual %b", want.is_tag, out_mon.is_tag);
            fail_count <= fail_count + 1;
          end
        end
      end
      // The keystream uses the registers as they stand when the word is taken.
      if (in_mon.valid && in_mon.ready)
        predict_word(in_mon.kind, {in_mon.block_high, in_mon.block_low});
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:3])
          agcm_pkg::REG_KEY_HIGH[1:0]: key_hi <= cfg_pwdata;
          agcm_pkg::REG_KEY_LOW[1:0]:  key_lo <= cfg_pwdata;
          agcm_pkg::REG_IV_HIGH[1:0]:  iv_hi  <= cfg_pwdata;
          agcm_pkg::REG_IV_LOW[1:0]:   iv_lo  <= cfg_pwdata[31:0];
          default: ;
        endcase
      end
      words_pending <= expected_results.size();
    end
  end
endmodule

// ===== sim/tb_aes128_gcm_encrypt.sv =====
`timescale 1ns / 100ps

module tb_aes128_gcm_encrypt;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [4:0]  cfg_paddr;
  logic [63:0] cfg_pwdata, cfg_prdata;
  int          fail_count, words_pending, words_sent;
  logic        send_no_gaps, take_no_gaps, long_hold;

  agcm_in_if  in_ch ();
  agcm_out_if out_ch ();

  aes128_gcm_encrypt uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  gcm_checker u_check (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_pready(cfg_pready), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .fail_count(fail_count), .words_pending(words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #25ms;
    $display("simulation failed");
    $finish;
  end

  // Result side: random stalls, and one long hold-off on request.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (700) @(posedge clk);
        long_hold <= 1'b0;
      end else begin
        gap = take_no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_word(input agcm_pkg::kind_t kind, input logic [127:0] blk);
    int gap;
    gap = send_no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.block_high <= blk[127:64];
    in_ch.block_low <= blk[63:0];
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  function automatic logic [127:0] random_block();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom, $urandom, $urandom};
    endcase
  endfunction

  task automatic send_message(input int data_words, input logic close_it);
    for (int i = 0; i < data_words; i++) send_word(agcm_pkg::KIND_DATA, random_block());
    if (close_it) send_word(agcm_pkg::KIND_FINISH, random_block());
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx[1:0], 3'b000};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  function automatic logic [63:0] random_reg();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic load_all(input logic [63:0] kh, kl, ih, il);
    write_reg(agcm_pkg::REG_KEY_HIGH, kh);
    write_reg(agcm_pkg::REG_KEY_LOW, kl);
    write_reg(agcm_pkg::REG_IV_HIGH, ih);
    write_reg(agcm_pkg::REG_IV_LOW, il);
  endtask

  initial begin
    int len;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = agcm_pkg::KIND_DATA;
    in_ch.block_high = '0;
    in_ch.block_low = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    send_no_gaps = 1'b0;
    take_no_gaps = 1'b0;
    long_hold = 1'b0;
    words_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers at their reset values: empty message first, then extreme blocks.
    send_word(agcm_pkg::KIND_FINISH, '1);
    send_word(agcm_pkg::KIND_DATA, '0);
    send_word(agcm_pkg::KIND_DATA, '1);
    send_word(agcm_pkg::KIND_FINISH, '0);
    wait_drained();

    load_all('1, '1, '1, '1);
    send_no_gaps = 1'b1;
    send_word(agcm_pkg::KIND_DATA, {32{4'h5}});
    send_word(agcm_pkg::KIND_DATA, {32{4'ha}});
    send_word(agcm_pkg::KIND_FINISH, '0);
    send_no_gaps = 1'b0;
    wait_drained();

    // Key and IV change while a message is open; H and the mask must not follow.
    load_all(random_reg(), random_reg(), random_reg(), {$urandom, $urandom});
    send_message(2, 1'b0);
    wait_drained();
    load_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
             {$urandom, $urandom});
    send_message(2, 1'b1);
    send_word(agcm_pkg::KIND_FINISH, '1);

    // Hold the result side off while words keep coming, then pause until drained.
    long_hold <= 1'b1;
    send_message(12, 1'b1);
    wait_drained();

    while (words_sent < 950) begin
      if ($urandom_range(0, 29) == 0) begin
        wait_drained();
        load_all(random_reg(), random_reg(), random_reg(), random_reg());
      end
      if ($urandom_range(0, 3) == 0) send_no_gaps = ~send_no_gaps;
      if ($urandom_range(0, 3) == 0) take_no_gaps = ~take_no_gaps;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      send_message(len, 1'b1);
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    for (int i = 0; i < 50000 && words_pending != 0; i++) @(posedge clk);
    if (words_pending != 0) begin
      $error("%0d result words never arrived", words_pending);
      $display("simulation failed");
    end else begin
      repeat (20) @(posedge clk);
      if (fail_count == 0) begin
        $display("simulation ok");
      end else begin
        $display("simulation failed");
      end
    end
    $finish;
  end
endmodule
